// ----- hw/rtl/irclim_pkg.sv -----
// irclim_pkg: shared types, constants and frame layout for the ir climate frame transmitter
`default_nettype none

package irclim_pkg;

	// frame geometry
	localparam int FRAME_BYTES = 14;
	localparam int FRAME_BITS  = FRAME_BYTES * 8;
	localparam int BIT_IDX_W   = 7;
	localparam int BYTE_IDX_W  = 4;

	// defaults for the top level parameters
	localparam int             TICK_WIDTH_DEF  = 16;
	localparam logic [7:0]     UNIT_F_CODE_DEF = 8'd1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_MARK    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HEAT_MODE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SWING_MASK   = 3'd7;

	// item kinds carried in tuser
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// fixed frame content
	localparam logic [7:0] HDR_BYTE [5] = '{8'h23, 8'hCB, 8'h26, 8'h01, 8'h00};
	localparam logic [7:0] HDR_SUM      = 8'h15;
	localparam logic [7:0] BYTE5_BASE   = 8'h20;
	localparam logic [7:0] POWER_BIT    = 8'h04;

	// temperature rules
	localparam logic signed [7:0] HEAT_LO   = 8'sd13;
	localparam logic signed [7:0] HEAT_HI   = 8'sd26;
	localparam logic        [7:0] HEAT_BASE = 8'd26;
	localparam logic signed [7:0] COOL_LO   = 8'sd16;
	localparam logic signed [7:0] COOL_HI   = 8'sd32;
	localparam logic        [7:0] COOL_BASE = 8'd31;

	// waveform phases
	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_LEAD_MARK  = 3'd1,
		PH_LEAD_SPACE = 3'd2,
		PH_BIT_MARK   = 3'd3,
		PH_BIT_SPACE  = 3'd4,
		PH_STOP       = 3'd5
	} phase_t;

	// configuration register bank
	typedef struct packed {
		logic [15:0] leader_mark_ticks;
		logic [15:0] leader_space_ticks;
		logic [15:0] bit_mark_ticks;
		logic [15:0] one_space_ticks;
		logic [15:0] zero_space_ticks;
		logic [15:0] stop_mark_ticks;
		logic [7:0]  heat_mode_code;
		logic [7:0]  swing_mask;
	} cfg_t;

	// settings carried by a load beat
	typedef struct packed {
		logic              power_on;
		logic [7:0]        ac_mode_code;
		logic signed [7:0] temp_celsius;
		logic [2:0]        fan_speed;
		logic              swing_on;
		logic              fahrenheit_display;
	} settings_t;

	// one result beat
	typedef struct packed {
		logic ir_mark;
		logic busy_res;
		logic frame_done;
		logic load_refused;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/irclim_frame_build.sv -----
// irclim_frame_build: frame assembly, frame byte store and current bit lookup
`default_nettype none

module irclim_frame_build #(
	parameter logic [7:0] UNIT_F_CODE = irclim_pkg::UNIT_F_CODE_DEF
) (
	input  wire                                   clk,
	input  wire                                   wr_en,
	input  irclim_pkg::settings_t                 settings,
	input  irclim_pkg::cfg_t                      cfg,
	input  wire [irclim_pkg::BIT_IDX_W-1:0]       bit_idx,
	output logic                                  cur_bit
);
	import irclim_pkg::*;

	logic [7:0] frame_q [FRAME_BYTES];

	logic              heat;
	logic signed [7:0] t_lo;
	logic signed [7:0] t_hi;
	logic signed [7:0] t_clamped;
	logic [7:0]        t_base;
	logic              over;
	logic [7:0]        byte5;
	logic [7:0]        byte7;
	logic [7:0]        byte8;
	logic [7:0]        byte11;
	logic [7:0]        byte12;
	logic [7:0]        csum;
	logic [BYTE_IDX_W-1:0] byte_idx;

	// temperature clamp and offset code
	always_comb begin
		heat   = (settings.ac_mode_code == cfg.heat_mode_code);
		t_lo   = heat ? HEAT_LO : COOL_LO;
		t_hi   = heat ? HEAT_HI : COOL_HI;
		t_base = heat ? HEAT_BASE : COOL_BASE;
		if (settings.temp_celsius < t_lo) begin
			t_clamped = t_lo;
		end else if (settings.temp_celsius > t_hi) begin
			t_clamped = t_hi;
		end else begin
			t_clamped = settings.temp_celsius;
		end
		over   = !heat && (t_clamped >= COOL_HI);
		byte7  = over ? 8'd0 : (t_base - 8'(t_clamped));
		byte11 = over ? 8'd1 : 8'd0;
	end

	// remaining variable bytes and checksum
	always_comb begin
		byte5  = BYTE5_BASE | (settings.power_on ? POWER_BIT : 8'd0);
		byte8  = {5'd0, settings.fan_speed} | (settings.swing_on ? cfg.swing_mask : 8'd0);
		byte12 = settings.fahrenheit_display ? UNIT_F_CODE : 8'd0;
		csum   = HDR_SUM + byte5 + settings.ac_mode_code + byte7 + byte8 + byte11 + byte12;
	end

	// frame store, whole frame written by one load
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < 5; i++) begin
				frame_q[i] <= HDR_BYTE[i];
			end
			frame_q[5]  <= byte5;
			frame_q[6]  <= settings.ac_mode_code;
			frame_q[7]  <= byte7;
			frame_q[8]  <= byte8;
			frame_q[9]  <= 8'd0;
			frame_q[10] <= 8'd0;
			frame_q[11] <= byte11;
			frame_q[12] <= byte12;
			frame_q[13] <= csum;
		end
	end

	// lsb-first bit select
	always_comb begin
		byte_idx = bit_idx[BIT_IDX_W-1:3];
		if (byte_idx < BYTE_IDX_W'(FRAME_BYTES)) begin
			cur_bit = frame_q[byte_idx][bit_idx[2:0]];
		end else begin
			cur_bit = 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/irclim_wave_seq.sv -----
// irclim_wave_seq: pulse-distance waveform sequencer with phase, bit and tick counters
`default_nettype none

module irclim_wave_seq #(
	parameter int TICK_WIDTH = irclim_pkg::TICK_WIDTH_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               step,
	input  wire                               kind,
	input  irclim_pkg::cfg_t                  cfg,
	input  wire                               cur_bit,
	output logic [irclim_pkg::BIT_IDX_W-1:0]  bit_idx,
	output logic                              frame_wr,
	output irclim_pkg::result_t               result
);
	import irclim_pkg::*;

	localparam logic [32:0] TickMax = (33'd1 << TICK_WIDTH) - 33'd1;

	phase_t                phase_q, phase_d;
	logic [BIT_IDX_W-1:0]  bit_q, bit_d;
	logic [TICK_WIDTH-1:0] tick_q, tick_d;

	logic                  busy;
	logic                  is_load;
	logic                  is_mark;
	logic [15:0]           dur_raw;
	logic [32:0]           dur_ext;
	logic [TICK_WIDTH-1:0] dur_len;
	logic [TICK_WIDTH-1:0] tick_inc;
	logic                  phase_end;
	logic                  last_bit;

	assign is_load = (kind == KIND_LOAD);
	assign bit_idx = bit_q;

	// phase decode, duration select and tick compare
	always_comb begin
		busy    = 1'b1;
		is_mark = 1'b0;
		dur_raw = cfg.stop_mark_ticks;
		unique case (phase_q)
			PH_LEAD_MARK: begin
				dur_raw = cfg.leader_mark_ticks;
				is_mark = 1'b1;
			end
			PH_LEAD_SPACE: begin
				dur_raw = cfg.leader_space_ticks;
			end
			PH_BIT_MARK: begin
				dur_raw = cfg.bit_mark_ticks;
				is_mark = 1'b1;
			end
			PH_BIT_SPACE: begin
				dur_raw = cur_bit ? cfg.one_space_ticks : cfg.zero_space_ticks;
			end
			PH_STOP: begin
				is_mark = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
		// zero counts as one tick, saturate at counter range
		dur_ext = {17'd0, (dur_raw == 16'd0) ? 16'd1 : dur_raw};
		dur_len = (dur_ext > TickMax) ? {TICK_WIDTH{1'b1}} : dur_ext[TICK_WIDTH-1:0];
		tick_inc  = tick_q + TICK_WIDTH'(1);
		phase_end = (tick_inc >= dur_len) || (tick_inc == '0);
		last_bit  = ({1'b0, bit_q} + 8'd1) >= 8'(FRAME_BITS);
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		tick_d  = tick_q;
		if (step) begin
			if (is_load) begin
				if (!busy) begin
					phase_d = PH_LEAD_MARK;
					bit_d   = '0;
					tick_d  = '0;
				end
			end else if (!busy) begin
				phase_d = PH_IDLE;
			end else if (!phase_end) begin
				tick_d = tick_inc;
			end else begin
				tick_d = '0;
				unique case (phase_q)
					PH_LEAD_MARK: begin
						phase_d = PH_LEAD_SPACE;
					end
					PH_LEAD_SPACE: begin
						phase_d = PH_BIT_MARK;
						bit_d   = '0;
					end
					PH_BIT_MARK: begin
						phase_d = PH_BIT_SPACE;
					end
					PH_BIT_SPACE: begin
						if (last_bit) begin
							phase_d = PH_STOP;
							bit_d   = '0;
						end else begin
							phase_d = PH_BIT_MARK;
							bit_d   = bit_q + BIT_IDX_W'(1);
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// result beat and frame write
	always_comb begin
		frame_wr = step && is_load && !busy;
		if (is_load) begin
			result.ir_mark      = 1'b0;
			result.busy_res     = 1'b1;
			result.frame_done   = 1'b0;
			result.load_refused = busy;
		end else begin
			result.ir_mark      = busy && is_mark;
			result.busy_res     = busy;
			result.frame_done   = busy && phase_end && (phase_q == PH_STOP);
			result.load_refused = 1'b0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			tick_q  <= '0;
		end else begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/ir_climate_frame_transmitter_core.sv -----
// ir_climate_frame_transmitter_core: top level with beat registers and configuration bank
`default_nettype none

// Pulse-distance IR transmitter for a 14-byte climate-unit frame. A load beat
// (tuser = 0) builds the frame and starts it; every tick beat (tuser = 1)
// moves the waveform on by one time unit and returns one result beat that
// says whether the carrier is on. One beat is taken every clock cycle while the
// result side does not stall; each beat passes the input register, then the frame
// and sequencer logic, then the result register. A load during a frame is refused
// and reported. Configuration is written through its own channel; the user must
// write it only while the block is idle, which the block itself does not enforce.

module ir_climate_frame_transmitter_core #(
	parameter int         TICK_WIDTH  = irclim_pkg::TICK_WIDTH_DEF,
	parameter logic [7:0] UNIT_F_CODE = irclim_pkg::UNIT_F_CODE_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// input beats
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// power_on[0], ac_mode_code[8:1], temp_celsius[16:9], fan_speed[19:17],
	// swing_on[20], fahrenheit_display[21], zero[23:22]
	input  wire [23:0]                         s_axis_tdata,
	// mode[0]
	input  wire                                s_axis_tuser,
	// result beats
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// ir_mark[0], busy_res[1], load_refused[2], zero[7:3]
	output logic [7:0]                         m_axis_tdata,
	// frame_done
	output logic                               m_axis_tlast,
	// configuration writes
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [irclim_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [irclim_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import irclim_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	logic      kind_s1;
	settings_t settings_s1;
	logic      advance;
	logic      cur_bit;
	logic      frame_wr;
	logic [BIT_IDX_W-1:0] bit_idx;
	result_t   result;
	result_t   result_s2;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// configuration bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_mark_ticks  <= 16'd9000;
			cfg_q.leader_space_ticks <= 16'd4500;
			cfg_q.bit_mark_ticks     <= 16'd560;
			cfg_q.one_space_ticks    <= 16'd1690;
			cfg_q.zero_space_ticks   <= 16'd560;
			cfg_q.stop_mark_ticks    <= 16'd560;
			cfg_q.heat_mode_code     <= 8'd1;
			cfg_q.swing_mask         <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LEADER_MARK:  cfg_q.leader_mark_ticks  <= cfg_data;
				REG_LEADER_SPACE: cfg_q.leader_space_ticks <= cfg_data;
				REG_BIT_MARK:     cfg_q.bit_mark_ticks     <= cfg_data;
				REG_ONE_SPACE:    cfg_q.one_space_ticks    <= cfg_data;
				REG_ZERO_SPACE:   cfg_q.zero_space_ticks   <= cfg_data;
				REG_STOP_MARK:    cfg_q.stop_mark_ticks    <= cfg_data;
				REG_HEAT_MODE:    cfg_q.heat_mode_code     <= cfg_data[7:0];
				REG_SWING_MASK:   cfg_q.swing_mask         <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1                        <= s_axis_tuser;
			settings_s1.power_on           <= s_axis_tdata[0];
			settings_s1.ac_mode_code       <= s_axis_tdata[8:1];
			settings_s1.temp_celsius       <= s_axis_tdata[16:9];
			settings_s1.fan_speed          <= s_axis_tdata[19:17];
			settings_s1.swing_on           <= s_axis_tdata[20];
			settings_s1.fahrenheit_display <= s_axis_tdata[21];
		end
	end

	irclim_frame_build #(
		.UNIT_F_CODE (UNIT_F_CODE)
	) u_frame_build (
		.clk      (clk),
		.wr_en    (frame_wr),
		.settings (settings_s1),
		.cfg      (cfg_q),
		.bit_idx  (bit_idx),
		.cur_bit  (cur_bit)
	);

	irclim_wave_seq #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_wave_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.kind     (kind_s1),
		.cfg      (cfg_q),
		.cur_bit  (cur_bit),
		.bit_idx  (bit_idx),
		.frame_wr (frame_wr),
		.result   (result)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tdata = {5'd0, result_s2.load_refused, result_s2.busy_res, result_s2.ir_mark};
	assign m_axis_tlast = result_s2.frame_done;

endmodule

`default_nettype wire

// ----- bench/ir_climate_frame_transmitter_core_tb.sv -----
// ir_climate_frame_transmitter_core_tb: self-checking bench for the ir climate frame transmitter
`timescale 1ns / 1ps

module ir_climate_frame_transmitter_core_tb;
	import irclim_pkg::*;

	localparam int         CYCLE_LIMIT = 200_000;
	localparam int         HOLD_CYCLES = 400;
	localparam int         DRAIN_WAIT  = 4;
	localparam logic [7:0] HEAD_BYTES [5] = '{8'h23, 8'hCB, 8'h26, 8'h01, 8'h00};
	localparam logic [7:0] F_UNIT_CODE = 8'd1;

	// tracks the waveform position and holds the pulses still to come out
	class ir_pulse_tracker;
		phase_t      phase;
		int          bit_idx;
		logic [15:0] tick_cnt;
		logic [15:0] span_reg [6];
		logic [7:0]  heat_code;
		logic [7:0]  swing_mask;
		logic [7:0]  frame [FRAME_BYTES];
		result_t     pulse_queue [$];
		int          failures;

		function new();
			span_reg = '{16'd9000, 16'd4500, 16'd560, 16'd1690, 16'd560, 16'd560};
			heat_code = 8'd1;
			swing_mask = 8'd8;
			frame = '{default: 8'h00};
			phase = PH_IDLE;
			bit_idx = 0;
			tick_cnt = '0;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				REG_HEAT_MODE: heat_code = data[7:0];
				REG_SWING_MASK: swing_mask = data[7:0];
				default: span_reg[idx] = data;
			endcase
		endfunction

		// zero length counts as a single tick
		function int ticks_of(logic [15:0] v);
			return (v == 16'd0) ? 1 : int'(v);
		endfunction

		function void assemble_frame(settings_t s);
			int t;
			int lo;
			int hi;
			int base;
			bit heat;
			bit over;
			logic [7:0] sum;
			heat = (s.ac_mode_code == heat_code);
			t = $signed(s.temp_celsius);
			lo = heat ? 13 : 16;
			hi = heat ? 26 : 32;
			base = heat ? 26 : 31;
			if (t < lo) t = lo;
			if (t > hi) t = hi;
			over = !heat && (t >= 32);
			frame = '{default: 8'h00};
			for (int i = 0; i < 5; i++) frame[i] = HEAD_BYTES[i];
			frame[5] = 8'h20 | (s.power_on ? 8'h04 : 8'h00);
			frame[6] = s.ac_mode_code;
			frame[7] = over ? 8'h00 : 8'(base - t);
			frame[8] = {5'b0, s.fan_speed} | (s.swing_on ? swing_mask : 8'h00);
			frame[11] = {7'b0, over};
			frame[12] = s.fahrenheit_display ? F_UNIT_CODE : 8'h00;
			sum = 8'h00;
			for (int i = 0; i < 13; i++) sum += frame[i];
			frame[13] = sum;
		endfunction

		// work out the pulse caused by one accepted input beat
		function void take_beat(logic kind, logic [23:0] data);
			result_t   r;
			settings_t s;
			bit        active;
			int        span;
			logic      cur_bit;
			r = '0;
			active = (phase != PH_IDLE);
			if (kind == KIND_LOAD) begin
				r.busy_res = 1'b1;
				r.load_refused = active;
				if (!active) begin
					s.power_on = data[0];
					s.ac_mode_code = data[8:1];
					s.temp_celsius = data[16:9];
					s.fan_speed = data[19:17];
					s.swing_on = data[20];
					s.fahrenheit_display = data[21];
					assemble_frame(s);
					phase = PH_LEAD_MARK;
					bit_idx = 0;
					tick_cnt = '0;
				end
			end else if (active) begin
				r.busy_res = 1'b1;
				cur_bit = frame[bit_idx >> 3][bit_idx & 7];
				case (phase)
					PH_LEAD_MARK: begin
						span = ticks_of(span_reg[REG_LEADER_MARK]);
						r.ir_mark = 1'b1;
					end
					PH_LEAD_SPACE: span = ticks_of(span_reg[REG_LEADER_SPACE]);
					PH_BIT_MARK: begin
						span = ticks_of(span_reg[REG_BIT_MARK]);
						r.ir_mark = 1'b1;
					end
					PH_BIT_SPACE: span = ticks_of(cur_bit ? span_reg[REG_ONE_SPACE]
						: span_reg[REG_ZERO_SPACE]);
					default: begin
						span = ticks_of(span_reg[REG_STOP_MARK]);
						r.ir_mark = 1'b1;
					end
				endcase
				tick_cnt = tick_cnt + 16'd1;
				// end of the current mark or space
				if (tick_cnt >= span || tick_cnt == 16'd0) begin
					tick_cnt = '0;
					case (phase)
						PH_LEAD_MARK: phase = PH_LEAD_SPACE;
						PH_LEAD_SPACE: begin
							phase = PH_BIT_MARK;
							bit_idx = 0;
						end
						PH_BIT_MARK: phase = PH_BIT_SPACE;
						PH_BIT_SPACE: begin
							if (bit_idx == FRAME_BITS - 1) begin
								phase = PH_STOP;
								bit_idx = 0;
							end else begin
								bit_idx++;
								phase = PH_BIT_MARK;
							end
						end
						default: begin
							phase = PH_IDLE;
							r.frame_done = 1'b1;
						end
					endcase
				end
			end
			pulse_queue.insert(pulse_queue.size(), r);
		endfunction

		function void compare_field(string name, logic want, logic got);
			if (got !== want) begin
				$error("%s: expected %0b, got %0b", name, want, got);
				failures++;
			end
		endfunction

		// compare one result beat with the oldest outstanding pulse
		function void check_pulse(logic [7:0] data, logic last);
			result_t want;
			if (pulse_queue.size() == 0) begin
				$error("result beat with nothing outstanding: tdata %h tlast %b", data, last);
				failures++;
				return;
			end
			want = pulse_queue.pop_front();
			compare_field("ir_mark", want.ir_mark, data[0]);
			compare_field("busy_res", want.busy_res, data[1]);
			compare_field("frame_done", want.frame_done, last);
			compare_field("load_refused", want.load_refused, data[2]);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	wire                   s_axis_tready;
	logic [23:0]           s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	wire                   m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	wire [7:0]             m_axis_tdata;
	wire                   m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	wire                   cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ir_pulse_tracker tracker = new();
	bit              idle_on = 1'b1;
	bit              hold_request = 1'b0;
	int              cycle_count = 0;

	ir_climate_frame_transmitter_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [23:0] pack_load(settings_t s);
		return {2'b00, s.fahrenheit_display, s.swing_on, s.fan_speed, s.temp_celsius,
			s.ac_mode_code, s.power_on};
	endfunction

	// random settings, half of them in heating mode, half near the clamp limits
	function automatic settings_t random_settings();
		settings_t s;
		s.power_on = 1'($urandom);
		s.ac_mode_code = $urandom_range(0, 1) ? tracker.heat_code : 8'($urandom);
		s.temp_celsius = $urandom_range(0, 1) ? 8'($urandom_range(8, 36)) : 8'($urandom);
		s.fan_speed = 3'($urandom);
		s.swing_on = 1'($urandom);
		s.fahrenheit_display = 1'($urandom);
		return s;
	endfunction

	task automatic send_beat(input logic kind, input logic [23:0] data);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_beat(kind, data);
	endtask

	task automatic send_tick();
		send_beat(KIND_TICK, {2'b00, 22'($urandom)});
	endtask

	task automatic load_registers(input logic [15:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			tracker.write_reg(CFG_IDX_W'(i), vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// tick until the frame in flight has gone out
	task automatic finish_frame();
		while (tracker.phase != PH_IDLE) send_tick();
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (tracker.pulse_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// result side: random stalls plus one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			gap = idle_on ? $urandom_range(0, 5) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			tracker.check_pulse(m_axis_tdata, m_axis_tlast);
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [15:0] vals [8];
		settings_t   corner [6];

		corner[0] = '{1'b1, 8'h05, -8'sd128, 3'd7, 1'b1, 1'b1};
		corner[1] = '{1'b0, 8'h05, 8'sd127, 3'd0, 1'b0, 1'b0};
		corner[2] = '{1'b1, 8'h00, 8'sd32, 3'd5, 1'b1, 1'b0};
		corner[3] = '{1'b0, 8'hFF, 8'sd31, 3'd2, 1'b0, 1'b1};
		corner[4] = '{1'b1, 8'h80, -8'sd128, 3'd3, 1'b0, 1'b0};
		corner[5] = '{1'b0, 8'h7F, 8'sd127, 3'd6, 1'b1, 1'b1};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick while idle, then short spans with zero lengths and masked byte registers
		send_tick();
		settle();
		vals[REG_LEADER_MARK] = 16'd0;
		vals[REG_LEADER_SPACE] = 16'd1;
		vals[REG_BIT_MARK] = 16'd0;
		vals[REG_ONE_SPACE] = 16'd2;
		vals[REG_ZERO_SPACE] = 16'd1;
		vals[REG_STOP_MARK] = 16'd0;
		vals[REG_HEAT_MODE] = 16'hA505;
		vals[REG_SWING_MASK] = 16'h5AFF;
		load_registers(vals);

		// temperature clamps and over-range flag, one frame each with a refused load
		for (int k = 0; k < 6; k += 2) begin
			send_beat(KIND_LOAD, pack_load(corner[k]));
			send_beat(KIND_LOAD, pack_load(corner[k + 1]));
			send_tick();
			finish_frame();
			send_tick();
		end
		settle();

		// random settings with short spans and a long hold-off on the result side
		vals[REG_LEADER_MARK] = 16'($urandom_range(0, 3));
		vals[REG_LEADER_SPACE] = 16'($urandom_range(0, 3));
		vals[REG_BIT_MARK] = 16'($urandom_range(0, 2));
		vals[REG_ONE_SPACE] = 16'($urandom_range(0, 3));
		vals[REG_ZERO_SPACE] = 16'($urandom_range(0, 2));
		vals[REG_STOP_MARK] = 16'($urandom_range(0, 3));
		vals[REG_HEAT_MODE] = 16'($urandom);
		case ($urandom_range(0, 2))
			0: vals[REG_SWING_MASK] = 16'h0000;
			1: vals[REG_SWING_MASK] = 16'hFFFF;
			default: vals[REG_SWING_MASK] = 16'($urandom);
		endcase
		load_registers(vals);
		hold_request = 1'b1;
		repeat (30) begin
			if ($urandom_range(0, 9) == 0)
				send_beat(KIND_LOAD, pack_load(random_settings()));
			else
				send_tick();
		end
		finish_frame();
		settle();

		// long leader mark, all-ones heat code and empty swing mask, no idling
		idle_on = 1'b0;
		vals[REG_LEADER_MARK] = 16'd64;
		vals[REG_LEADER_SPACE] = 16'd1;
		vals[REG_BIT_MARK] = 16'd1;
		vals[REG_ONE_SPACE] = 16'd2;
		vals[REG_ZERO_SPACE] = 16'd1;
		vals[REG_STOP_MARK] = 16'd1;
		vals[REG_HEAT_MODE] = 16'hFFFF;
		vals[REG_SWING_MASK] = 16'hFF00;
		load_registers(vals);
		send_beat(KIND_LOAD, pack_load(random_settings()));
		finish_frame();
		send_tick();
		settle();

		if (tracker.pulse_queue.size() != 0) begin
			$error("%0d result beats never arrived", tracker.pulse_queue.size());
			tracker.failures++;
		end
		if (tracker.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/irclim_pkg.sv
hw/rtl/irclim_frame_build.sv
hw/rtl/irclim_wave_seq.sv
hw/rtl/ir_climate_frame_transmitter_core.sv
bench/ir_climate_frame_transmitter_core_tb.sv
